### hw/rtl/ppcd_pkg.sv
package ppcd_pkg;

  localparam int DurWidth    = 21;
  localparam int CodeWidth   = 12;
  localparam int CodeBitsDef = 12;
  localparam int QueueDepth  = 4;
  localparam int MinElements = 20;
  localparam int ElemCntW    = 5;

  localparam int AddrWidth = 4;
  localparam int DataWidth = 32;

  localparam logic [15:0] ShortReset = 16'd555;
  localparam logic [15:0] LongReset  = 16'd1111;
  localparam logic [6:0]  TolReset   = 7'd40;
  localparam logic [3:0]  EarlyReset = 4'd10;

  // floor(p / 100) for p < 2**23: q0 = (p * 41943) >> 22 is q or q - 1
  localparam int Divisor    = 100;
  localparam int RecipMul   = 41943;
  localparam int RecipShift = 22;
  localparam int ProdW      = 23;
  localparam int TolW       = 17;
  localparam int SettleCycles = 4;

  typedef enum logic [1:0] {
    REG_SHORT = 2'd0,
    REG_LONG  = 2'd1,
    REG_TOL   = 2'd2,
    REG_EARLY = 2'd3
  } reg_idx_t;

  typedef logic signed [DurWidth-1:0] dur_t;
  typedef logic [DurWidth-1:0] mag_t;
  typedef logic [CodeWidth-1:0] code_t;

  typedef struct packed {
    logic [15:0] lo;
    logic [17:0] hi;
  } bound_t;

  typedef struct packed {
    bound_t      short_b;
    bound_t      long_b;
    logic [3:0]  early_end_bits;
    logic        busy;
  } cfg_t;

  typedef struct packed {
    mag_t mag;
    logic neg;
    logic is_short;
    logic is_long;
    logic first;
    logic last;
  } elem_t;

  function automatic logic in_bounds(mag_t m, bound_t b);
    return (m >= DurWidth'(b.lo)) && (m <= DurWidth'(b.hi));
  endfunction

endpackage

### hw/rtl/ppcd_regs.sv
module ppcd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppcd_pkg::AddrWidth-1:0] paddr,
  input  logic [ppcd_pkg::DataWidth-1:0] pwdata,
  output logic [ppcd_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output ppcd_pkg::cfg_t                cfg
);
  import ppcd_pkg::*;

  localparam int SetW = $clog2(SettleCycles + 1);

  logic [15:0] short_duration;
  logic [15:0] long_duration;
  logic [6:0]  tolerance_percent;
  logic [3:0]  early_end_bits;
  logic [SetW-1:0] settle;

  logic [ProdW-1:0] prod [2];
  logic [ProdW-1:0] prod_d [2];
  logic [TolW-1:0]  quot [2];
  logic [TolW-1:0]  tol [2];
  logic [15:0]      nom [2];
  bound_t           bnd [2];

  logic     wr;
  reg_idx_t idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign nom[0] = short_duration;
  assign nom[1] = long_duration;

  always_comb begin
    unique case (idx)
      REG_SHORT: prdata = DataWidth'(short_duration);
      REG_LONG:  prdata = DataWidth'(long_duration);
      REG_TOL:   prdata = DataWidth'(tolerance_percent);
      REG_EARLY: prdata = DataWidth'(early_end_bits);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_duration    <= ShortReset;
      long_duration     <= LongReset;
      tolerance_percent <= TolReset;
      early_end_bits    <= EarlyReset;
      settle            <= SetW'(SettleCycles);
    end else if (wr) begin
      settle <= SetW'(SettleCycles);
      unique case (idx)
        REG_SHORT: short_duration    <= pwdata[15:0];
        REG_LONG:  long_duration     <= pwdata[15:0];
        REG_TOL:   tolerance_percent <= pwdata[6:0];
        REG_EARLY: early_end_bits    <= pwdata[3:0];
        default:   ;
      endcase
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  // tolerance window pipeline: product, reciprocal, correction, bounds
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      prod[i]   <= ProdW'(nom[i]) * ProdW'(tolerance_percent);
      prod_d[i] <= prod[i];
      quot[i]   <= TolW'((40'(prod[i]) * 40'(RecipMul)) >> RecipShift);
      if ((prod_d[i] - ProdW'(quot[i]) * ProdW'(Divisor)) >= ProdW'(Divisor)) begin
        tol[i] <= quot[i] + 1'b1;
      end else begin
        tol[i] <= quot[i];
      end
      bnd[i].lo <= (tol[i] > TolW'(nom[i])) ? 16'd0 : 16'(TolW'(nom[i]) - tol[i]);
      bnd[i].hi <= 18'(nom[i]) + 18'(tol[i]);
    end
  end

  assign cfg.short_b        = bnd[0];
  assign cfg.long_b         = bnd[1];
  assign cfg.early_end_bits = early_end_bits;
  assign cfg.busy           = (settle != '0);

endmodule

### hw/rtl/ppcd_fifo.sv
module ppcd_fifo #(
  parameter int DEPTH = ppcd_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ppcd_pkg::elem_t wr_data,
  input  logic            rd_en,
  output ppcd_pkg::elem_t rd_data,
  output logic            full,
  output logic            empty
);
  import ppcd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  elem_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/ppcd_front.sv
module ppcd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ppcd_pkg::dur_t       duration,
  input  logic                 first_element,
  input  logic                 last_element,
  input  ppcd_pkg::cfg_t       cfg,
  output logic                 q_wr,
  output ppcd_pkg::elem_t      q_data,
  input  logic                 q_full
);
  import ppcd_pkg::*;

  logic valid;
  dur_t dur;
  logic first;
  logic last;
  mag_t mag;
  logic take;

  assign full = cfg.busy || (valid && q_full);
  assign take = push && !full;
  assign q_wr = valid && !q_full;
  assign mag  = dur[DurWidth-1] ? mag_t'(-dur) : mag_t'(dur);

  assign q_data.mag      = mag;
  assign q_data.neg      = dur[DurWidth-1];
  assign q_data.is_short = in_bounds(mag, cfg.short_b);
  assign q_data.is_long  = in_bounds(mag, cfg.long_b);
  assign q_data.first    = first;
  assign q_data.last     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (q_wr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dur   <= duration;
      first <= first_element;
      last  <= last_element;
    end
  end

endmodule

### hw/rtl/ppcd_back.sv
module ppcd_back #(
  parameter int CODE_BITS = ppcd_pkg::CodeBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ppcd_pkg::cfg_t       cfg,
  input  ppcd_pkg::elem_t      q_data,
  input  logic                 q_empty,
  output logic                 q_rd,
  output logic                 empty,
  input  logic                 pop,
  output ppcd_pkg::code_t      code,
  output logic                 status
);
  import ppcd_pkg::*;

  localparam int CntW = $clog2(CODE_BITS + 1);
  localparam int CmpW = (CntW > 4) ? CntW : 4;

  logic                 expect_gap, expect_gap_next;
  mag_t                 held_mag, held_mag_next;
  logic [CODE_BITS-1:0] shift_bits, shift_bits_next;
  logic [CntW-1:0]      bit_total, bit_total_next;
  logic                 capture_done, capture_done_next;
  logic                 decoded_ok, decoded_ok_next;
  logic                 result_sent, result_sent_next;
  logic [ElemCntW-1:0]  elem_count, elem_count_next;
  logic [ElemCntW-1:0]  index;
  logic                 zero_bit;
  logic                 one_bit;
  logic                 emit_ok;
  logic                 emit_fail;
  code_t                out_code;
  logic                 out_valid;

  assign empty = !out_valid;
  assign q_rd  = !q_empty && (!out_valid || pop);

  always_comb begin
    expect_gap_next   = expect_gap;
    held_mag_next     = held_mag;
    shift_bits_next   = shift_bits;
    bit_total_next    = bit_total;
    capture_done_next = capture_done;
    decoded_ok_next   = decoded_ok;
    result_sent_next  = result_sent;
    elem_count_next   = elem_count;
    zero_bit          = 1'b0;
    one_bit           = 1'b0;

    if (q_data.first) begin
      expect_gap_next   = 1'b0;
      held_mag_next     = '0;
      shift_bits_next   = '0;
      bit_total_next    = '0;
      capture_done_next = 1'b0;
      decoded_ok_next   = 1'b0;
      result_sent_next  = 1'b0;
      elem_count_next   = '0;
    end

    index = elem_count_next;
    if (elem_count_next < ElemCntW'(MinElements)) begin
      elem_count_next = elem_count_next + 1'b1;
    end

    if (!capture_done_next) begin
      if (!expect_gap_next) begin
        if (q_data.neg) begin
          // leading gap is skipped, a later negative pulse fails the capture
          if (index != '0) begin
            capture_done_next = 1'b1;
          end
        end else begin
          held_mag_next   = q_data.mag;
          expect_gap_next = 1'b1;
        end
      end else begin
        expect_gap_next = 1'b0;
        zero_bit = in_bounds(held_mag_next, cfg.short_b) && q_data.is_long;
        one_bit  = !zero_bit && in_bounds(held_mag_next, cfg.long_b) && q_data.is_short;
        if (zero_bit || one_bit) begin
          shift_bits_next = CODE_BITS'({shift_bits_next, one_bit});
          bit_total_next  = bit_total_next + 1'b1;
          if (bit_total_next >= CntW'(CODE_BITS)) begin
            capture_done_next = 1'b1;
            decoded_ok_next   = 1'b1;
          end
        end else if (CmpW'(bit_total_next) >= CmpW'(cfg.early_end_bits)) begin
          capture_done_next = 1'b1;
        end else begin
          shift_bits_next = '0;
          bit_total_next  = '0;
        end
      end
    end

    emit_ok   = decoded_ok_next && !result_sent_next &&
                (elem_count_next >= ElemCntW'(MinElements));
    emit_fail = !emit_ok && q_data.last && !result_sent_next;
    if (emit_ok || emit_fail) begin
      result_sent_next = 1'b1;
    end

    // code is taken before the end-of-capture restart
    out_code = emit_ok ? code_t'(shift_bits_next) : '0;

    if (q_data.last) begin
      expect_gap_next   = 1'b0;
      held_mag_next     = '0;
      shift_bits_next   = '0;
      bit_total_next    = '0;
      capture_done_next = 1'b0;
      decoded_ok_next   = 1'b0;
      result_sent_next  = 1'b0;
      elem_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_gap   <= 1'b0;
      held_mag     <= '0;
      shift_bits   <= '0;
      bit_total    <= '0;
      capture_done <= 1'b0;
      decoded_ok   <= 1'b0;
      result_sent  <= 1'b0;
      elem_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (q_rd) begin
        expect_gap   <= expect_gap_next;
        held_mag     <= held_mag_next;
        shift_bits   <= shift_bits_next;
        bit_total    <= bit_total_next;
        capture_done <= capture_done_next;
        decoded_ok   <= decoded_ok_next;
        result_sent  <= result_sent_next;
        elem_count   <= elem_count_next;
      end
      if (q_rd && (emit_ok || emit_fail)) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && (emit_ok || emit_fail)) begin
      code   <= out_code;
      status <= emit_fail;
    end
  end

endmodule

### hw/rtl/pulse_pair_code_decoder.sv
// Channel   Handshake            Payload
// config    psel/penable/pready  paddr, pwdata, prdata (APB, regs at 4*i)
// elements  push / full          duration, first_element, last_element
// results   pop / empty          code, status
//
// One element per cycle sustained while full is low. An element passes the
// front register and the queue, then updates the decode state; a result it
// causes is on the ports from that update. full is held after reset and
// after every register write while the tolerance window pipeline settles.
// Input and result sides stall independently through a short element queue.
module pulse_pair_code_decoder #(
  parameter int CODE_BITS   = ppcd_pkg::CodeBitsDef,
  parameter int QUEUE_DEPTH = ppcd_pkg::QueueDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppcd_pkg::AddrWidth-1:0] paddr,
  input  logic [ppcd_pkg::DataWidth-1:0] pwdata,
  output logic [ppcd_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  input  logic                           push,
  output logic                           full,
  input  ppcd_pkg::dur_t                 duration,
  input  logic                           first_element,
  input  logic                           last_element,
  output logic                           empty,
  input  logic                           pop,
  output ppcd_pkg::code_t                code,
  output logic                           status
);
  import ppcd_pkg::*;

  cfg_t  cfg;
  elem_t wr_data;
  elem_t rd_data;
  logic  q_wr;
  logic  q_rd;
  logic  q_full;
  logic  q_empty;

  ppcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppcd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .duration      (duration),
    .first_element (first_element),
    .last_element  (last_element),
    .cfg           (cfg),
    .q_wr          (q_wr),
    .q_data        (wr_data),
    .q_full        (q_full)
  );

  ppcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (wr_data),
    .rd_en   (q_rd),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  ppcd_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_data  (rd_data),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .code    (code),
    .status  (status)
  );

endmodule

### verif/pulse_pair_code_decoder_checker.sv
module pulse_pair_code_decoder_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppcd_pkg::AddrWidth-1:0] paddr,
  input  logic [ppcd_pkg::DataWidth-1:0] pwdata,
  input  logic                           pready,
  input  logic                           push,
  input  logic                           full,
  input  ppcd_pkg::dur_t                 duration,
  input  logic                           first_element,
  input  logic                           last_element,
  input  logic                           empty,
  input  logic                           pop,
  input  ppcd_pkg::code_t                code,
  input  logic                           status,
  output int                             errors,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppcd_pkg::*;

  localparam int PercentScale = 100;

  typedef struct packed {
    code_t code;
    logic  status;
  } code_result_t;

  code_result_t expected_codes[$];
  int           fail_tally = 0;

  logic [15:0] short_nom;
  logic [15:0] long_nom;
  logic [6:0]  tol_pct;
  logic [3:0]  early_bits;

  logic        expect_gap;
  dur_t        held_pulse;
  code_t       shift_bits;
  int unsigned bit_total;
  int unsigned elem_count;
  logic        capture_done;
  logic        decoded_ok;
  logic        result_sent;

  function automatic void clear_capture();
    expect_gap   = 1'b0;
    held_pulse   = '0;
    shift_bits   = '0;
    bit_total    = 0;
    elem_count   = 0;
    capture_done = 1'b0;
    decoded_ok   = 1'b0;
    result_sent  = 1'b0;
  endfunction

  // magnitude within nominal +/- floor(nominal * pct / 100)
  function automatic logic in_window(dur_t value, logic [15:0] nom);
    longint mag;
    longint tol;
    mag = (value < 0) ? -longint'(value) : longint'(value);
    tol = (longint'(nom) * longint'(tol_pct)) / PercentScale;
    return (mag >= longint'(nom) - tol) && (mag <= longint'(nom) + tol);
  endfunction

  function automatic void decode_element(dur_t dur, logic first, logic last);
    int unsigned  idx;
    logic         zero_bit;
    logic         one_bit;
    code_result_t res;
    if (first) clear_capture();
    idx = elem_count;
    if (elem_count < MinElements) elem_count++;
    if (!capture_done) begin
      if (!expect_gap) begin
        if (dur < 0) begin
          if (idx != 0) capture_done = 1'b1;
        end else begin
          held_pulse = dur;
          expect_gap = 1'b1;
        end
      end else begin
        expect_gap = 1'b0;
        zero_bit = in_window(held_pulse, short_nom) && in_window(dur, long_nom);
        one_bit  = !zero_bit && in_window(held_pulse, long_nom) &&
                   in_window(dur, short_nom);
        if (zero_bit || one_bit) begin
          shift_bits = {shift_bits[CodeWidth-2:0], one_bit};
          bit_total++;
          if (bit_total >= CodeBitsDef) begin
            capture_done = 1'b1;
            decoded_ok   = 1'b1;
          end
        end else if (bit_total >= early_bits) begin
          capture_done = 1'b1;
        end else begin
          shift_bits = '0;
          bit_total  = 0;
        end
      end
    end
    if (decoded_ok && !result_sent && elem_count >= MinElements) begin
      res.code   = shift_bits;
      res.status = 1'b0;
      expected_codes.push_back(res);
      result_sent = 1'b1;
    end else if (last && !result_sent) begin
      res.code   = '0;
      res.status = 1'b1;
      expected_codes.push_back(res);
      result_sent = 1'b1;
    end
    if (last) clear_capture();
  endfunction

  always @(posedge clk) begin
    code_result_t head;
    if (rst) begin
      short_nom  = ShortReset;
      long_nom   = LongReset;
      tol_pct    = TolReset;
      early_bits = EarlyReset;
      clear_capture();
      expected_codes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_SHORT: short_nom  = pwdata[15:0];
          REG_LONG:  long_nom   = pwdata[15:0];
          REG_TOL:   tol_pct    = pwdata[6:0];
          REG_EARLY: early_bits = pwdata[3:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_codes.size() == 0) begin
          fail_tally++;
          $display("%0t: unexpected result, expected none, got code %h status %0b",
                   $time, code, status);
        end else begin
          head = expected_codes.pop_front();
          if (code !== head.code) begin
            fail_tally++;
            $display("%0t: code mismatch, expected %h, got %h", $time, head.code, code);
          end
          if (status !== head.status) begin
            fail_tally++;
            $display("%0t: status mismatch, expected %0b, got %0b",
                     $time, head.status, status);
          end
        end
      end
      if (push && !full) decode_element(duration, first_element, last_element);
    end
    outstanding <= expected_codes.size();
    errors      <= fail_tally;
  end

endmodule

### verif/pulse_pair_code_decoder_tb.sv
module pulse_pair_code_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppcd_pkg::*;

  localparam int ItemGoal    = 1350;
  localparam int PhaseItems  = 160;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;
  localparam int DurMax      = 1048575;
  localparam int DurMin      = -1048576;

  typedef struct {
    dur_t dur;
    logic first;
    logic last;
  } pulse_rec_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 push;
  logic                 full;
  dur_t                 duration;
  logic                 first_element;
  logic                 last_element;
  logic                 empty;
  logic                 pop;
  code_t                code;
  logic                 status;
  int                   errors;
  int                   outstanding;

  int          cycles = 0;
  int          sent;
  logic        quiet;
  int unsigned cur_short;
  int unsigned cur_long;
  int unsigned cur_tol;
  pulse_rec_t  burst_q[$];

  pulse_pair_code_decoder DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .duration, .first_element, .last_element,
    .empty, .pop, .code, .status
  );

  pulse_pair_code_decoder_checker checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .push, .full, .duration, .first_element, .last_element,
    .empty, .pop, .code, .status, .errors, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls per transfer
  initial begin
    int stall;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  task automatic push_item(dur_t dur, logic first, logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    duration      <= dur;
    first_element <= first;
    last_element  <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apply_setting(int phase);
    int unsigned early;
    case (phase)
      1: begin
        cur_short = 1; cur_long = 65535; cur_tol = 0; early = 0;
      end
      2: begin
        cur_short = 65535; cur_long = 1; cur_tol = 100; early = 12;
      end
      3: begin
        cur_short = 300; cur_long = 900; cur_tol = 127; early = 15;
      end
      4: begin
        cur_short = ShortReset; cur_long = LongReset; cur_tol = TolReset;
        early = EarlyReset;
      end
      default: begin
        cur_short = $urandom_range(50, 3000);
        cur_long  = cur_short * $urandom_range(2, 4);
        cur_tol   = $urandom_range(0, 60);
        early     = $urandom_range(0, 12);
        if ($urandom_range(0, 7) == 0) begin
          cur_tol = $urandom_range(61, 127);
          early   = $urandom_range(0, 15);
        end
      end
    endcase
    write_reg(REG_SHORT, cur_short);
    write_reg(REG_LONG, cur_long);
    write_reg(REG_TOL, cur_tol);
    write_reg(REG_EARLY, early);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // length inside the match window, edges favored
  function automatic int near_len(int unsigned nom);
    int unsigned t;
    int unsigned lo;
    int unsigned hi;
    t  = nom * cur_tol / 100;
    lo = (t > nom) ? 0 : nom - t;
    hi = nom + t;
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int miss_len(int unsigned nom);
    int unsigned t;
    int unsigned lo;
    int unsigned hi;
    t  = nom * cur_tol / 100;
    lo = (t > nom) ? 0 : nom - t;
    hi = nom + t + 1 + $urandom_range(0, nom / 4);
    if (lo > 0 && $urandom_range(0, 1) == 0) return $urandom_range(0, lo - 1);
    return (hi > DurMax) ? DurMax : hi;
  endfunction

  function automatic void add_elem(int d);
    pulse_rec_t rec;
    rec.dur   = dur_t'(d);
    rec.first = 1'b0;
    rec.last  = 1'b0;
    burst_q.push_back(rec);
  endfunction

  function automatic void add_bit(int unsigned one);
    int g;
    add_elem(near_len((one != 0) ? cur_long : cur_short));
    g = near_len((one != 0) ? cur_short : cur_long);
    add_elem(($urandom_range(0, 9) == 0) ? g : -g);
  endfunction

  function automatic void add_bad();
    if ($urandom_range(0, 1) == 0) begin
      add_elem(near_len(cur_short));
      add_elem(-near_len(cur_short));
    end else begin
      add_elem(miss_len(cur_short));
      add_elem(-near_len(cur_long));
    end
  endfunction

  task automatic run_capture();
    int kind;
    int noise;
    burst_q.delete();
    kind  = $urandom_range(0, 99);
    quiet = ($urandom_range(0, 4) == 0);
    if (kind < 92 && $urandom_range(0, 2) == 0) add_elem(-near_len(cur_long));
    if (kind < 55) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 5)) add_bit($urandom_range(0, 1));
        add_bad();
      end
      repeat (CodeBitsDef) add_bit($urandom_range(0, 1));
      repeat ($urandom_range(0, 3)) add_bit($urandom_range(0, 1));
    end else if (kind < 70) begin
      repeat ($urandom_range(0, CodeBitsDef - 1)) add_bit($urandom_range(0, 1));
      add_bad();
      repeat ($urandom_range(0, 4)) add_bit($urandom_range(0, 1));
    end else if (kind < 80) begin
      repeat ($urandom_range(0, 8)) add_bit($urandom_range(0, 1));
      add_elem(-near_len(cur_short));
      repeat ($urandom_range(0, 3)) add_bit($urandom_range(0, 1));
    end else if (kind < 92) begin
      repeat ($urandom_range(0, CodeBitsDef)) begin
        if ($urandom_range(0, 5) == 0) add_bad();
        else add_bit($urandom_range(0, 1));
      end
    end else begin
      repeat ($urandom_range(1, 30)) begin
        case ($urandom_range(0, 5))
          0: noise = DurMax;
          1: noise = DurMin;
          default: noise = int'(dur_t'($urandom()));
        endcase
        add_elem(noise);
        burst_q[$].first = ($urandom_range(0, 3) == 0);
        burst_q[$].last  = ($urandom_range(0, 3) == 0);
      end
    end
    if (kind < 92) begin
      if ($urandom_range(0, 3) == 0) add_elem(near_len(cur_short));
      if (burst_q.size() == 0) add_elem(near_len(cur_long));
      burst_q[0].first = ($urandom_range(0, 7) != 0);
      burst_q[$].last  = ($urandom_range(0, 11) != 0);
    end
    foreach (burst_q[i]) push_item(burst_q[i].dur, burst_q[i].first, burst_q[i].last);
  endtask

  initial begin
    int phase;
    int phase_start;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    push          <= 1'b0;
    duration      <= '0;
    first_element <= 1'b0;
    last_element  <= 1'b0;
    quiet     = 1'b0;
    sent      = 0;
    cur_short = ShortReset;
    cur_long  = LongReset;
    cur_tol   = TolReset;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // one-element captures at the range extremes
    push_item(dur_t'(DurMax), 1'b1, 1'b1);
    push_item(dur_t'(DurMin), 1'b1, 1'b1);
    // leading gap, a 0 bit, then a negative pulse
    push_item(dur_t'(DurMin), 1'b1, 1'b0);
    push_item(dur_t'(555), 1'b0, 1'b0);
    push_item(dur_t'(-1111), 1'b0, 1'b0);
    push_item(dur_t'(-5), 1'b0, 1'b0);
    push_item(dur_t'(0), 1'b0, 1'b1);
    // positive leading pulse forming a 1 bit, bad pair of zeros, unpaired final pulse
    push_item(dur_t'(1111), 1'b1, 1'b0);
    push_item(dur_t'(555), 1'b0, 1'b0);
    push_item(dur_t'(0), 1'b0, 1'b0);
    push_item(dur_t'(0), 1'b0, 1'b0);
    push_item(dur_t'(555), 1'b0, 1'b1);
    // last mark with no first mark
    push_item(dur_t'(555), 1'b0, 1'b1);
    // abandoned capture restarted by a first mark
    push_item(dur_t'(777), 1'b1, 1'b0);
    push_item(dur_t'(-777), 1'b1, 1'b1);
    // window edges: inside, then just outside
    push_item(dur_t'(333), 1'b1, 1'b0);
    push_item(dur_t'(-1555), 1'b0, 1'b0);
    push_item(dur_t'(332), 1'b0, 1'b0);
    push_item(dur_t'(-1556), 1'b0, 1'b1);

    phase       = 0;
    phase_start = sent;
    while (sent < ItemGoal) begin
      if (sent - phase_start >= PhaseItems) begin
        phase++;
        drain();
        apply_setting(phase);
        phase_start = sent;
      end
      run_capture();
    end

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
